// File: src/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned CpW      = 21;
	localparam int unsigned PartialW = 15;
	localparam int unsigned PendW    = 2;
	localparam int unsigned ChunkW   = 6;

	// continuation byte count still expected
	localparam logic [PendW-1:0] PEND_NONE  = 2'd0;
	localparam logic [PendW-1:0] PEND_ONE   = 2'd1;
	localparam logic [PendW-1:0] PEND_TWO   = 2'd2;
	localparam logic [PendW-1:0] PEND_THREE = 2'd3;

	// byte class tags (top bits of the byte)
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	typedef struct packed {
		logic [PendW-1:0]    pend;
		logic [PartialW-1:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic           emit;
		logic [CpW-1:0] code_point;
	} dec_result_t;

endpackage

// File: src/u8dec_if.sv
// ----------------------------------------------------------------------------
// u8dec_byte_if / u8dec_cp_if
// Valid/ready channels for raw text bytes and decoded code points.
// ----------------------------------------------------------------------------
interface u8dec_byte_if
	import u8dec_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8dec_cp_if
	import u8dec_pkg::*;
	();
	logic           valid;
	logic           ready;
	logic [CpW-1:0] code_point;

	modport source (output valid, output code_point, input ready);
	modport sink   (input valid, input code_point, output ready);
endinterface

// File: src/utf8_to_code_point_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Decodes a UTF-8 byte stream into code points, one byte per clock unless stalled.
// ----------------------------------------------------------------------------
//  channel  dir  payload            request
//  utf8     in   in_byte[7:0]       one text byte, zero ends a string
//  points   out  code_point[20:0]   one decoded character
//
//  A byte is registered at acceptance in the input register and decoded from
//  there; its code point, if any, goes into the output register.
//  One byte is taken every clock unless points stalls; state_q loops via u8dec_step.
//  A stall on points holds a byte that completes a character in the input
//  register; bytes that give nothing still move on.
//  arst_n clears the sequence state and both valid flags.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder
	import u8dec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	u8dec_byte_if.sink           utf8,
	u8dec_cp_if.source           points
);

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             out_valid_q;
	logic [CpW-1:0]   code_point_q;
	dec_state_t       state_q;
	dec_state_t       state_d;
	dec_result_t      res;
	logic             out_free;
	logic             adv;

	u8dec_step u_step (
		.in_byte (byte_s1),
		.cur     (state_q),
		.nxt     (state_d),
		.res     (res)
	);

	assign out_free   = !out_valid_q || points.ready;
	assign adv        = valid_s1 && (!res.emit || out_free);
	assign utf8.ready = !valid_s1 || adv;

	assign points.valid      = out_valid_q;
	assign points.code_point = code_point_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (utf8.ready) begin
			valid_s1 <= utf8.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (utf8.ready && utf8.valid) begin
			byte_s1 <= utf8.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{pend: PEND_NONE, partial: '0};
		end else if (adv) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (points.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			code_point_q <= res.code_point;
		end
	end

	// no open sequence means no gathered bits
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend == PEND_NONE |-> state_q.partial == '0)
		else $error("partial bits left with no sequence open");

	// a fresh four-byte lead holds only three payload bits
	a_lead4_width: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend == PEND_THREE |-> state_q.partial[PartialW-1:3] == '0)
		else $error("four-byte sequence holds too many bits");

	// a result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.emit |-> out_free)
		else $error("result register overwritten");

	// end of string closes any sequence
	a_nul_drops: assert property (@(posedge clk) disable iff (!arst_n)
		adv && byte_s1 == '0 |=> state_q.pend == PEND_NONE)
		else $error("sequence survives end of string");

endmodule

// File: src/u8dec_step.sv
// ----------------------------------------------------------------------------
// u8dec_step
// Next-state and result logic for one byte of UTF-8 text.
// ----------------------------------------------------------------------------
module u8dec_step
	import u8dec_pkg::*;
(
	input  logic [ByteW-1:0] in_byte,
	input  dec_state_t       cur,
	output dec_state_t       nxt,
	output dec_result_t      res
);

	logic [CpW-1:0]      joined;
	logic [PartialW-1:0] shifted;

	assign joined  = {cur.partial, in_byte[ChunkW-1:0]};
	assign shifted = {cur.partial[PartialW-ChunkW-1:0], in_byte[ChunkW-1:0]};

	always_comb begin
		nxt            = '{pend: PEND_NONE, partial: '0};
		res.emit       = 1'b0;
		res.code_point = joined;
		priority if (in_byte == '0) begin
			// end of string drops whatever is open
		end else if (cur.pend != PEND_NONE) begin
			if (in_byte[7:6] != CONT_TAG) begin
				// bad continuation, consumed with the sequence
			end else if (cur.pend == PEND_ONE) begin
				res.emit = 1'b1;
			end else begin
				nxt.pend    = cur.pend - PEND_ONE;
				nxt.partial = shifted;
			end
		end else if (!in_byte[7]) begin
			res.emit       = 1'b1;
			res.code_point = {{(CpW-ByteW){1'b0}}, in_byte};
		end else if (in_byte[7:5] == LEAD2_TAG) begin
			nxt.pend    = PEND_ONE;
			nxt.partial = {{(PartialW-5){1'b0}}, in_byte[4:0]};
		end else if (in_byte[7:4] == LEAD3_TAG) begin
			nxt.pend    = PEND_TWO;
			nxt.partial = {{(PartialW-4){1'b0}}, in_byte[3:0]};
		end else if (in_byte[7:3] == LEAD4_TAG) begin
			nxt.pend    = PEND_THREE;
			nxt.partial = {{(PartialW-3){1'b0}}, in_byte[2:0]};
		end else begin
			// stray continuation or 0xf8..0xff lead
		end
	end

endmodule
